### rtl/his_pkg.sv
`timescale 1ns / 1ps

package his_pkg;

	localparam int KEY_W = 32;
	localparam int POS_W = 6;
	localparam int OUT_TDATA_W = 40;

	typedef enum logic [3:0] {
		OP_LOAD,
		OP_INIT,
		OP_TOP,
		OP_POP1,
		OP_POP2,
		OP_HELD,
		OP_Q,
		OP_SIFT,
		OP_RA,
		OP_RB,
		OP_CMP,
		OP_FIN,
		OP_ERD,
		OP_EKEY,
		OP_EOUT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic in_ready;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic start_sort;
		logic init_done;
		logic left_zero;
		logic right_one;
		logic c_in_range;
		logic sink;
		logic emit_done;
		logic out_free;
	} status_t;

endpackage

### rtl/his_ctrl.sv
`timescale 1ns / 1ps

module his_ctrl import his_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t sts,
	output cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_LOAD,
		S_INIT,
		S_TOP,
		S_POP1,
		S_POP2,
		S_HELD,
		S_Q,
		S_SIFT,
		S_RA,
		S_RB,
		S_CMP,
		S_FIN,
		S_ERD,
		S_EKEY,
		S_EOUT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			case (state_q)
				S_LOAD: if (sts.start_sort) state_q <= S_INIT;
				S_INIT: if (sts.init_done) state_q <= S_TOP;
				S_TOP:  state_q <= sts.left_zero ? S_POP1 : S_HELD;
				S_POP1: state_q <= S_POP2;
				S_POP2: state_q <= sts.right_one ? S_FIN : S_Q;
				S_HELD: state_q <= S_Q;
				S_Q:    state_q <= S_SIFT;
				S_SIFT: state_q <= sts.c_in_range ? S_RA : S_TOP;
				S_RA:   state_q <= S_RB;
				S_RB:   state_q <= S_CMP;
				S_CMP:  state_q <= sts.sink ? S_SIFT : S_TOP;
				S_FIN:  state_q <= S_ERD;
				S_ERD:  state_q <= S_EKEY;
				S_EKEY: state_q <= S_EOUT;
				S_EOUT: begin
					if (sts.out_free) state_q <= sts.emit_done ? S_LOAD : S_ERD;
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	always_comb begin
		cmd.in_ready = 1'b0;
		case (state_q)
			S_LOAD: begin
				cmd.op = OP_LOAD;
				cmd.in_ready = sts.out_free || !sts.count_zero;
			end
			S_INIT:  cmd.op = OP_INIT;
			S_TOP:   cmd.op = OP_TOP;
			S_POP1:  cmd.op = OP_POP1;
			S_POP2:  cmd.op = OP_POP2;
			S_HELD:  cmd.op = OP_HELD;
			S_Q:     cmd.op = OP_Q;
			S_SIFT:  cmd.op = OP_SIFT;
			S_RA:    cmd.op = OP_RA;
			S_RB:    cmd.op = OP_RB;
			S_CMP:   cmd.op = OP_CMP;
			S_FIN:   cmd.op = OP_FIN;
			S_ERD:   cmd.op = OP_ERD;
			S_EKEY:  cmd.op = OP_EKEY;
			S_EOUT:  cmd.op = OP_EOUT;
			default: cmd.op = OP_LOAD;
		endcase
	end

endmodule

### rtl/his_datapath.sv
`timescale 1ns / 1ps

module his_datapath import his_pkg::*; #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output status_t          sts,
	input  logic             s_axis_tvalid,
	input  logic [KEY_W-1:0] s_axis_tdata,
	input  logic             s_axis_tlast,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [POS_W-1:0] out_position,
	output logic [KEY_W-1:0] out_key,
	output logic             m_axis_tlast,
	input  logic             cfg_valid,
	input  logic             cfg_data
);

	localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CW = $clog2(MAX_ELEMENTS + 1);

	logic [KEY_W-1:0] key_mem [MAX_ELEMENTS];
	logic [AW-1:0]    idx_mem [MAX_ELEMENTS];

	logic [KEY_W-1:0] key_rd_q;
	logic [AW-1:0]    idx_rd_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] n_q;
	logic [AW-1:0] k_q;
	logic [AW-1:0] left_q;
	logic [AW-1:0] right_q;
	logic [AW:0]   c_q;
	logic [AW-1:0] i_q;
	logic [AW-1:0] held_q;
	logic [AW-1:0] ia_q;
	logic [AW-1:0] ib_q;
	logic [KEY_W-1:0] q_q;
	logic [KEY_W-1:0] ka_q;
	logic descending_q;

	logic out_valid_q;
	logic [POS_W-1:0] out_pos_q;
	logic [KEY_W-1:0] out_key_q;
	logic out_last_q;

	logic in_fire;
	logic count_full;
	logic out_free;
	logic out_load;
	logic c_lt_right;
	logic take_b;
	logic sink;
	logic [KEY_W-1:0] kc;
	logic [AW-1:0] ic;
	logic [AW:0] cn;

	logic key_we;
	logic key_re;
	logic [AW-1:0] key_ra;
	logic idx_we;
	logic [AW-1:0] idx_wa;
	logic [AW-1:0] idx_wd;
	logic idx_re;
	logic [AW-1:0] idx_ra;

	function automatic logic below(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b,
		input logic desc);
		logic lt;
		logic gt;
		lt = $signed(a) < $signed(b);
		gt = $signed(a) > $signed(b);
		return desc ? gt : lt;
	endfunction

	assign in_fire    = s_axis_tvalid && cmd.in_ready;
	assign count_full = (count_q == CW'(MAX_ELEMENTS));
	assign out_free   = !out_valid_q || m_axis_tready;
	assign c_lt_right = c_q < {1'b0, right_q};
	assign take_b     = c_lt_right && below(ka_q, key_rd_q, descending_q);
	assign kc         = take_b ? key_rd_q : ka_q;
	assign ic         = take_b ? ib_q : ia_q;
	assign cn         = take_b ? (c_q + 1'b1) : c_q;
	assign sink       = below(q_q, kc, descending_q);

	assign sts.count_zero = (count_q == '0);
	assign sts.start_sort = in_fire && s_axis_tlast && (count_q != '0);
	assign sts.init_done  = (CW'(k_q) == n_q - CW'(1));
	assign sts.left_zero  = (left_q == '0);
	assign sts.right_one  = (right_q == AW'(1));
	assign sts.c_in_range = (c_q <= {1'b0, right_q});
	assign sts.sink       = sink;
	assign sts.emit_done  = (CW'(k_q) == n_q - CW'(1));
	assign sts.out_free   = out_free;

	assign out_load = (cmd.op == OP_LOAD && in_fire && s_axis_tlast && count_q == '0) ||
		(cmd.op == OP_EOUT && out_free);
	assign key_we = (cmd.op == OP_LOAD) && in_fire && !count_full;

	always_comb begin
		idx_we = 1'b0;
		idx_wa = '0;
		idx_wd = '0;
		idx_re = 1'b0;
		idx_ra = '0;
		key_re = 1'b0;
		key_ra = '0;
		case (cmd.op)
			OP_INIT: begin
				idx_we = 1'b1;
				idx_wa = k_q;
				idx_wd = k_q;
			end
			OP_TOP: begin
				idx_re = 1'b1;
				idx_ra = (left_q == '0) ? right_q : left_q - 1'b1;
			end
			OP_POP1: begin
				idx_re = 1'b1;
			end
			OP_POP2: begin
				idx_we = 1'b1;
				idx_wa = right_q;
				idx_wd = idx_rd_q;
				key_re = 1'b1;
				key_ra = held_q;
			end
			OP_HELD: begin
				key_re = 1'b1;
				key_ra = idx_rd_q;
			end
			OP_SIFT: begin
				if (c_q <= {1'b0, right_q}) begin
					idx_re = 1'b1;
					idx_ra = c_q[AW-1:0];
				end else begin
					idx_we = 1'b1;
					idx_wa = i_q;
					idx_wd = held_q;
				end
			end
			OP_RA: begin
				key_re = 1'b1;
				key_ra = idx_rd_q;
				idx_re = 1'b1;
				idx_ra = c_q[AW-1:0] + 1'b1;
			end
			OP_RB: begin
				key_re = 1'b1;
				key_ra = idx_rd_q;
			end
			OP_CMP: begin
				idx_we = 1'b1;
				idx_wa = i_q;
				idx_wd = sink ? ic : held_q;
			end
			OP_FIN: begin
				idx_we = 1'b1;
				idx_wd = held_q;
			end
			OP_ERD: begin
				idx_re = 1'b1;
				idx_ra = k_q;
			end
			OP_EKEY: begin
				key_re = 1'b1;
				key_ra = idx_rd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (key_we) key_mem[count_q[AW-1:0]] <= s_axis_tdata;
		if (key_re) key_rd_q <= key_mem[key_ra];
	end

	always_ff @(posedge clk) begin
		if (idx_we) idx_mem[idx_wa] <= idx_wd;
		if (idx_re) idx_rd_q <= idx_mem[idx_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			n_q          <= '0;
			k_q          <= '0;
			left_q       <= '0;
			right_q      <= '0;
			c_q          <= '0;
			i_q          <= '0;
			descending_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) descending_q <= cfg_data;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_LOAD: begin
					if (in_fire) begin
						if (s_axis_tlast) begin
							count_q <= '0;
							n_q     <= count_full ? count_q : count_q + 1'b1;
							k_q     <= '0;
						end else if (!count_full) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				OP_INIT: begin
					k_q <= k_q + 1'b1;
					if (sts.init_done) begin
						left_q  <= AW'(n_q >> 1);
						right_q <= AW'(n_q - CW'(1));
					end
				end
				OP_TOP: begin
					if (left_q != '0) left_q <= left_q - 1'b1;
				end
				OP_POP2: right_q <= right_q - 1'b1;
				OP_Q: begin
					i_q <= left_q;
					c_q <= {left_q, 1'b1};
				end
				OP_CMP: begin
					if (sink) begin
						i_q <= cn[AW-1:0];
						c_q <= {cn[AW-1:0], 1'b1};
					end
				end
				OP_FIN: begin
					k_q     <= '0;
					right_q <= '0;
				end
				OP_EOUT: begin
					if (out_free) k_q <= k_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_POP1: held_q <= idx_rd_q;
			OP_HELD: held_q <= idx_rd_q;
			OP_Q:    q_q    <= key_rd_q;
			OP_RA:   ia_q   <= idx_rd_q;
			OP_RB: begin
				ka_q <= key_rd_q;
				ib_q <= idx_rd_q;
			end
			OP_EKEY: ia_q <= idx_rd_q;
			default: begin
			end
		endcase
		if (out_load) begin
			if (cmd.op == OP_LOAD) begin
				out_pos_q  <= '0;
				out_key_q  <= s_axis_tdata;
				out_last_q <= 1'b1;
			end else begin
				out_pos_q  <= POS_W'(ia_q);
				out_key_q  <= key_rd_q;
				out_last_q <= sts.emit_done;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign out_position  = out_pos_q;
	assign out_key       = out_key_q;
	assign m_axis_tlast  = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ELEMENTS))
		else $error("element count exceeds the store depth");

	a_sift_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_RA || cmd.op == OP_CMP) |-> (c_q <= {1'b0, right_q}))
		else $error("sift cursor left the heap");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("output register loaded while a beat is pending");

	a_accept_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> (cmd.op == OP_LOAD))
		else $error("input beat accepted outside the load phase");

	a_sort_starts: assert property (@(posedge clk) disable iff (!arst_n)
		sts.start_sort |=> (cmd.op == OP_INIT && k_q == '0 && count_q == '0))
		else $error("sort did not start cleanly after the last beat");

endmodule

### rtl/heap_index_sort.sv
`timescale 1ns / 1ps
// Index heapsort of signed 32-bit keys.
// Keys arrive as beats on the s_axis channel, one per beat, tdata holding the key.
// A beat with tlast set closes the set and starts the sort. Keys beyond
// MAX_ELEMENTS are dropped, but a dropped beat with tlast still starts the
// sort of the held set.
// The sort first writes the identity permutation, then runs the heap sift;
// every level of a sift steps through the SIFT, RA, RB and CMP states on the
// single read port of the index and key memories.
// Results leave on m_axis, one beat per element in rank order, each one read
// through the ERD, EKEY and EOUT states: position and key in tdata, tlast on the last.
// A set of one key is answered directly in the cycle after its beat.
// The descending bit on the cfg channel selects sort order; write it only idle.
// When the receiver stalls, the result register holds and the emit sequence waits.
// Reset clears the element count, the sort state and the descending bit; no
// memory clearing is needed, so the block is ready right after reset.
module heap_index_sort import his_pkg::*; #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [KEY_W-1:0]       s_axis_tdata,  // [31:0] key
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [5:0] position, [37:6] sorted_key
	output logic                   m_axis_tlast,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_data
);

	cmd_t             cmd;
	status_t          sts;
	logic [POS_W-1:0] out_position;
	logic [KEY_W-1:0] out_key;

	his_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	his_datapath #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.out_position  (out_position),
		.out_key       (out_key),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data)
	);

	assign s_axis_tready = cmd.in_ready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tdata  = {{(OUT_TDATA_W - POS_W - KEY_W){1'b0}}, out_key, out_position};

endmodule

### test/heap_index_sort_test.sv
`timescale 1ns / 1ps

module heap_index_sort_test;
	import his_pkg::*;

	localparam int MAX_KEYS = 64;
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [POS_W-1:0] pos;
		logic [KEY_W-1:0] key;
		logic             fin;
	} rank_t;

	class sorted_run_board;
		logic [KEY_W-1:0] keys[MAX_KEYS];
		int unsigned      held;
		bit               desc;
		rank_t            ranks_due[$];
		int               errors;

		function bit ranks_below(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
			return desc ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
		endfunction

		function void heap_order(int unsigned n);
			logic [POS_W-1:0] idx[MAX_KEYS];
			int unsigned      lft, rgt, i, c, k;
			logic [POS_W-1:0] top;
			logic [KEY_W-1:0] q;
			bit               done;
			rank_t            r;
			for (k = 0; k < n; k++)
				idx[k] = k[POS_W-1:0];
			lft = n / 2;
			rgt = n - 1;
			done = 0;
			while (!done) begin
				if (lft > 0) begin
					lft--;
					top = idx[lft];
				end else begin
					top = idx[rgt];
					idx[rgt] = idx[0];
					rgt--;
					if (rgt == 0) begin
						idx[0] = top;
						done = 1;
					end
				end
				if (!done) begin
					q = keys[top];
					i = lft;
					c = 2 * lft + 1;
					while (c <= rgt) begin
						if (c < rgt && ranks_below(keys[idx[c]], keys[idx[c + 1]]))
							c++;
						if (ranks_below(q, keys[idx[c]])) begin
							idx[i] = idx[c];
							i = c;
							c = 2 * c + 1;
						end else begin
							c = rgt + 1;
						end
					end
					idx[i] = top;
				end
			end
			for (k = 0; k < n; k++) begin
				r.pos = idx[k];
				r.key = keys[idx[k]];
				r.fin = (k + 1 == n);
				ranks_due.push_back(r);
			end
		endfunction

		function void note_key(logic [KEY_W-1:0] key, logic last);
			int unsigned n;
			rank_t       r;
			if (held < MAX_KEYS) begin
				keys[held] = key;
				held++;
			end
			if (last) begin
				n = held;
				held = 0;
				if (n == 1) begin
					r.pos = '0;
					r.key = keys[0];
					r.fin = 1'b1;
					ranks_due.push_back(r);
				end else begin
					heap_order(n);
				end
			end
		endfunction

		function void check_rank(logic [POS_W-1:0] pos, logic [KEY_W-1:0] key, logic fin,
				logic [1:0] pad);
			rank_t r;
			if (ranks_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected beat: pos %0d key %h last %b", pos, key, fin);
				return;
			end
			r = ranks_due.pop_front();
			if (pos !== r.pos || key !== r.key || fin !== r.fin || pad !== 2'b00) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected pos %0d key %h last %b, got pos %0d key %h last %b pad %b",
						r.pos, r.key, r.fin, pos, key, fin, pad);
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [KEY_W-1:0]       s_axis_tdata;
	logic                   s_axis_tlast;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic                   cfg_data;

	sorted_run_board board = new;
	int tx_idle;
	int rx_idle;
	int hold_left;
	int cycles;
	int keys_sent;

	heap_index_sort #(.MAX_ELEMENTS(MAX_KEYS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("heap_index_sort_test NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			board.check_rank(m_axis_tdata[POS_W-1:0], m_axis_tdata[POS_W+KEY_W-1:POS_W],
				m_axis_tlast, m_axis_tdata[OUT_TDATA_W-1:POS_W+KEY_W]);
		m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle);
	end

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(9))
			6, 7: pick_key = $urandom_range(8) - 4;
			8: pick_key = 32'h80000000 + $urandom_range(3);
			9: pick_key = 32'h7fffffff - $urandom_range(3);
			default: pick_key = $urandom;
		endcase
	endfunction

	function automatic int pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			pick_size = $urandom_range(10, 1);
		else if (r < 95)
			pick_size = $urandom_range(64, 11);
		else
			pick_size = $urandom_range(70, 64);
	endfunction

	task automatic send_key(input logic [KEY_W-1:0] key, input logic last);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= key;
		s_axis_tlast <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		board.note_key(key, last);
		keys_sent++;
		if ($urandom_range(99) < tx_idle) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic send_set(input int n);
		for (int k = 0; k < n; k++)
			send_key(pick_key(), k == n - 1);
	endtask

	// Stops the sender and waits out the sorted run plus the tail of the emit sequence.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (board.ranks_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_order(input logic desc);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= desc;
		do
			@(posedge clk);
		while (!cfg_ready);
		board.desc = desc;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(input int tx, input int rx, input logic desc, input int count);
		int stop;
		settle();
		tx_idle = tx;
		rx_idle <= rx;
		set_order(desc);
		stop = keys_sent + count;
		while (keys_sent < stop) begin
			send_set(pick_size());
			if ($urandom_range(5) == 0)
				set_order($urandom_range(1));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		tx_idle = 0;
		rx_idle = 0;
		hold_left = 0;
		cycles = 0;
		keys_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_order(1'b0);
		send_key(32'h80000000, 1'b1);
		send_key(32'h7fffffff, 1'b1);
		send_key(32'd5, 1'b0);
		send_key(32'd5, 1'b1);
		send_key(32'h7fffffff, 1'b0);
		send_key(32'h80000000, 1'b0);
		send_key(32'h00000000, 1'b0);
		send_key(32'hffffffff, 1'b0);
		send_key(32'h00000001, 1'b1);
		set_order(1'b1);
		send_key(32'd3, 1'b0);
		send_key(-32'sd3, 1'b0);
		send_key(32'd3, 1'b0);
		send_key(32'd0, 1'b0);
		send_key(-32'sd3, 1'b0);
		send_key(32'd3, 1'b1);
		send_key(32'h80000000, 1'b0);
		send_key(32'h7fffffff, 1'b0);
		send_key(32'haaaaaaaa, 1'b1);

		run_phase(13, 57, 1'b0, 100);
		run_phase(57, 13, 1'b1, 100);

		// A full store followed by dropped beats, the last of which closes the set.
		settle();
		tx_idle = 0;
		rx_idle <= 0;
		send_set(67);

		// The receiver holds off long enough for the input to back up.
		settle();
		hold_left <= 3000;
		for (int k = 0; k < 3; k++)
			send_set(12);
		run_phase(0, 0, 1'b0, 80);

		settle();
		if (board.errors == 0 && board.ranks_due.size() == 0)
			$display("heap_index_sort_test OK");
		else
			$display("heap_index_sort_test NOT OK");
		$finish;
	end

endmodule
